>>> hw/rtl/tfcc_pkg.sv
// shared types and constants for the thermal fan curve controller
package tfcc_pkg;

  localparam int TEMP_W    = 13;
  localparam int DUTY_W    = 12;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 13;

  typedef logic signed [TEMP_W-1:0] temp_t;
  typedef logic [DUTY_W-1:0]        duty_t;

  // configuration register map
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FAN_ON_TEMP  = 3'd0,
    CFG_FAN_MIN_TEMP = 3'd1,
    CFG_FAN_MAX_TEMP = 3'd2,
    CFG_DUTY_FLOOR   = 3'd3,
    CFG_DUTY_CEILING = 3'd4,
    CFG_FULL_ON_DUTY = 3'd5
  } cfg_idx_t;

  localparam temp_t RST_FAN_ON_TEMP  = 13'sd720;
  localparam temp_t RST_FAN_MIN_TEMP = 13'sd640;
  localparam temp_t RST_FAN_MAX_TEMP = 13'sd1120;
  localparam duty_t RST_DUTY_FLOOR   = 12'd200;
  localparam duty_t RST_DUTY_CEILING = 12'd1000;
  localparam duty_t RST_FULL_ON_DUTY = 12'd1000;

  localparam duty_t DUTY_MAX = 12'd4095;

endpackage

>>> hw/rtl/thermal_fan_curve_controller.sv
// thermal fan curve controller: iir filter, hysteresis and serial-divide duty curve
// sequence: an accepted item steps through the filter, decide, multiply, divide and finish states;
//   curve items use a one-bit-per-cycle restoring divider; others skip from decide to finish
// handshake: in_stall is high while an item is in work, so no new item enters until the last one
//   leaves ST_FIN; the next item may enter while the previous result waits on out_stall
// reset (synchronous, rst_n low): control and config registers back to defaults, filter unprimed, fan off
module thermal_fan_curve_controller #(
  parameter int FILTER_SHIFT = 3
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // sample input
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic signed [tfcc_pkg::TEMP_W-1:0]   in_sample_temp,
  // result output
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [tfcc_pkg::TEMP_W-1:0]   out_filtered_temp,
  output logic        [tfcc_pkg::DUTY_W-1:0]   out_fan_duty,
  // configuration writes
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [tfcc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic        [tfcc_pkg::CFG_DAT_W-1:0] cfg_data
);

  // accumulator holds the temperature with FILTER_SHIFT fraction bits
  localparam int ACC_W = tfcc_pkg::TEMP_W + FILTER_SHIFT;
  // magnitude of a difference of two accumulator-sized values
  localparam int AM_W  = ACC_W + 1;
  // numerator magnitude: temperature offset above min times duty span
  localparam int NUM_W = AM_W + tfcc_pkg::DUTY_W;
  localparam int CNT_W = $clog2(NUM_W + 1);
  localparam int SUM_W = NUM_W + 2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_FILT,
    ST_DECIDE,
    ST_MUL,
    ST_DIV,
    ST_FIN
  } state_t;

  // control state
  state_t                    state_r, state_nxt;
  logic                      primed_r, primed_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  tfcc_pkg::duty_t           last_duty_r, last_duty_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [CNT_W-1:0]          cnt_r, cnt_nxt;

  // configuration registers
  tfcc_pkg::temp_t           on_temp_r, min_temp_r, max_temp_r;
  tfcc_pkg::duty_t           floor_r, ceil_r, full_r;

  // payload / datapath registers
  tfcc_pkg::temp_t           sample_r, sample_nxt;
  tfcc_pkg::temp_t           out_temp_r, out_temp_nxt;
  tfcc_pkg::duty_t           out_duty_r, out_duty_nxt;
  tfcc_pkg::duty_t           duty_r, duty_nxt;
  logic                      use_div_r, use_div_nxt;
  logic                      neg_r, neg_nxt;
  logic [AM_W-1:0]           amag_r, amag_nxt;
  logic [tfcc_pkg::DUTY_W-1:0] dmag_r, dmag_nxt;
  logic [AM_W-1:0]           den_r, den_nxt;
  logic [AM_W-1:0]           rem_r, rem_nxt;
  logic [NUM_W-1:0]          quo_r, quo_nxt;

  // filter arithmetic
  logic signed [ACC_W-1:0]   target;
  logic signed [ACC_W:0]     fdiff;
  logic signed [ACC_W:0]     fstep;

  // scaled thresholds and curve operands
  logic signed [ACC_W-1:0]   on_s, min_s, max_s;
  logic                      run;
  logic signed [ACC_W:0]     adiff;
  logic signed [ACC_W:0]     span;
  logic signed [tfcc_pkg::DUTY_W:0] ddiff;

  // divider step
  logic [AM_W:0]             rem_sh;
  logic                      ge;

  // curve finish
  logic signed [SUM_W-1:0]   q_s;
  logic signed [SUM_W-1:0]   duty_s;
  tfcc_pkg::duty_t           curve_duty;
  tfcc_pkg::duty_t           fin_duty;

  assign cfg_ready         = 1'b1;
  assign in_stall          = (state_r != ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_filtered_temp = out_temp_r;
  assign out_fan_duty      = out_duty_r;

  // sample and thresholds moved onto the fixed-point grid
  assign target = $signed({sample_r, {FILTER_SHIFT{1'b0}}});
  assign on_s   = $signed({on_temp_r, {FILTER_SHIFT{1'b0}}});
  assign min_s  = $signed({min_temp_r, {FILTER_SHIFT{1'b0}}});
  assign max_s  = $signed({max_temp_r, {FILTER_SHIFT{1'b0}}});

  // iir step: acc + floor((target - acc) / 2^shift)
  assign fdiff = {target[ACC_W-1], target} - {acc_r[ACC_W-1], acc_r};
  assign fstep = fdiff >>> FILTER_SHIFT;

  // hysteresis: a stopped fan needs the on threshold, a running one the min threshold
  assign run   = (last_duty_r == '0) ? (acc_r > on_s) : (acc_r > min_s);
  assign adiff = {acc_r[ACC_W-1], acc_r} - {min_s[ACC_W-1], min_s};
  assign span  = {max_s[ACC_W-1], max_s} - {min_s[ACC_W-1], min_s};
  assign ddiff = $signed({1'b0, ceil_r}) - $signed({1'b0, floor_r});

  // restoring divider, one quotient bit per cycle
  assign rem_sh = {rem_r, quo_r[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den_r});

  // signed truncated quotient plus floor, then clamp to the duty range
  assign q_s    = neg_r ? -$signed({2'b00, quo_r}) : $signed({2'b00, quo_r});
  assign duty_s = q_s + $signed({{(SUM_W - tfcc_pkg::DUTY_W){1'b0}}, floor_r});

  always_comb begin
    if (duty_s < 0) begin
      curve_duty = '0;
    end else if (duty_s > $signed({{(SUM_W - tfcc_pkg::DUTY_W){1'b0}},
                                    tfcc_pkg::DUTY_MAX})) begin
      curve_duty = tfcc_pkg::DUTY_MAX;
    end else begin
      curve_duty = duty_s[tfcc_pkg::DUTY_W-1:0];
    end
  end

  assign fin_duty = use_div_r ? curve_duty : duty_r;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    primed_nxt    = primed_r;
    acc_nxt       = acc_r;
    last_duty_nxt = last_duty_r;
    out_valid_nxt = out_valid_r;
    cnt_nxt       = cnt_r;
    sample_nxt    = sample_r;
    out_temp_nxt  = out_temp_r;
    out_duty_nxt  = out_duty_r;
    duty_nxt      = duty_r;
    use_div_nxt   = use_div_r;
    neg_nxt       = neg_r;
    amag_nxt      = amag_r;
    dmag_nxt      = dmag_r;
    den_nxt       = den_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;

    // result register drains independently of the sequencer
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          sample_nxt = in_sample_temp;
          state_nxt  = ST_FILT;
        end
      end
      ST_FILT: begin
        // first sample after reset loads the filter directly
        if (!primed_r) begin
          acc_nxt    = target;
          primed_nxt = 1'b1;
        end else begin
          acc_nxt = acc_r + fstep[ACC_W-1:0];
        end
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        amag_nxt = adiff[ACC_W] ? AM_W'($unsigned(-adiff)) : AM_W'($unsigned(adiff));
        dmag_nxt = ddiff[tfcc_pkg::DUTY_W] ? tfcc_pkg::DUTY_W'($unsigned(-ddiff))
                                           : ddiff[tfcc_pkg::DUTY_W-1:0];
        neg_nxt  = adiff[ACC_W] ^ ddiff[tfcc_pkg::DUTY_W];
        den_nxt  = AM_W'($unsigned(span));
        if (!run) begin
          duty_nxt    = '0;
          use_div_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else if ((acc_r > max_s) || (max_s <= min_s)) begin
          // above the curve end, or a degenerate curve
          duty_nxt    = full_r;
          use_div_nxt = 1'b0;
          state_nxt   = ST_FIN;
        end else begin
          use_div_nxt = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        quo_nxt   = NUM_W'(amag_r * dmag_r);
        rem_nxt   = '0;
        cnt_nxt   = '0;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        rem_nxt = ge ? AM_W'(rem_sh - {1'b0, den_r}) : rem_sh[AM_W-1:0];
        quo_nxt = {quo_r[NUM_W-2:0], ge};
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == CNT_W'(NUM_W - 1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        // hold until the previous result has left
        if (!out_valid_r || !out_stall) begin
          last_duty_nxt = fin_duty;
          out_duty_nxt  = fin_duty;
          out_temp_nxt  = acc_r[ACC_W-1:FILTER_SHIFT];
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      primed_r    <= 1'b0;
      acc_r       <= '0;
      last_duty_r <= '0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      on_temp_r   <= tfcc_pkg::RST_FAN_ON_TEMP;
      min_temp_r  <= tfcc_pkg::RST_FAN_MIN_TEMP;
      max_temp_r  <= tfcc_pkg::RST_FAN_MAX_TEMP;
      floor_r     <= tfcc_pkg::RST_DUTY_FLOOR;
      ceil_r      <= tfcc_pkg::RST_DUTY_CEILING;
      full_r      <= tfcc_pkg::RST_FULL_ON_DUTY;
    end else begin
      state_r     <= state_nxt;
      primed_r    <= primed_nxt;
      acc_r       <= acc_nxt;
      last_duty_r <= last_duty_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      if (cfg_valid && cfg_ready) begin
        case (tfcc_pkg::cfg_idx_t'(cfg_index))
          tfcc_pkg::CFG_FAN_ON_TEMP:  on_temp_r  <= cfg_data;
          tfcc_pkg::CFG_FAN_MIN_TEMP: min_temp_r <= cfg_data;
          tfcc_pkg::CFG_FAN_MAX_TEMP: max_temp_r <= cfg_data;
          tfcc_pkg::CFG_DUTY_FLOOR:   floor_r    <= cfg_data[tfcc_pkg::DUTY_W-1:0];
          tfcc_pkg::CFG_DUTY_CEILING: ceil_r     <= cfg_data[tfcc_pkg::DUTY_W-1:0];
          tfcc_pkg::CFG_FULL_ON_DUTY: full_r     <= cfg_data[tfcc_pkg::DUTY_W-1:0];
          default: begin
            // writes beyond the map are dropped
          end
        endcase
      end
    end
    // datapath, no reset needed
    sample_r   <= sample_nxt;
    out_temp_r <= out_temp_nxt;
    out_duty_r <= out_duty_nxt;
    duty_r     <= duty_nxt;
    use_div_r  <= use_div_nxt;
    neg_r      <= neg_nxt;
    amag_r     <= amag_nxt;
    dmag_r     <= dmag_nxt;
    den_r      <= den_nxt;
    rem_r      <= rem_nxt;
    quo_r      <= quo_nxt;
  end

`ifndef SYNTHESIS
  // an accepted item always starts the sequencer
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r == ST_FILT))
    else $error("accepted item did not start filter step");

  // divider never runs past its bit count
  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (cnt_r < CNT_W'(NUM_W)))
    else $error("divider count overran");

  // the shown duty is the one that drives hysteresis
  a_duty_track: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_duty_r == last_duty_r))
    else $error("output duty differs from hysteresis state");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_stall) |=> ($stable(out_duty_r) && $stable(out_temp_r)))
    else $error("stalled result changed");
`endif

endmodule
